// ===== sv/nms_pkg.sv =====
`default_nettype none
package nms_pkg;

  localparam int MAX_KEPT    = 32;
  localparam int IDX_W       = $clog2(MAX_KEPT);
  localparam int CNT_W       = $clog2(MAX_KEPT + 1);
  localparam int CORNERS     = 4;
  localparam int COORDS      = 2 * CORNERS;
  localparam int COORD_IDX_W = $clog2(COORDS);
  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 4;
  localparam int PX_W        = COORD_W - FRAC_W;
  localparam int SPAN_W      = PX_W + 1;
  localparam int AREA_W      = 2 * PX_W + 1;
  localparam int UNI_W       = AREA_W + 1;
  localparam int THR_W       = 16;
  localparam int PROD_W      = UNI_W + THR_W;
  localparam int SUM_W       = 32;
  localparam int MCNT_W      = 16;
  localparam int DIVN_W      = SUM_W + 1;
  localparam int DSTEP_W     = $clog2(DIVN_W + 1);
  localparam int CONF_W      = 16;
  localparam int CLS_W       = 3;
  localparam int COL_W       = 2;
  localparam int MARK_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MCNT_W-1:0] MCNT_MAX = '1;

  localparam logic [MARK_W-1:0] MARK_MORE  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LAST  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NMS_IOU   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_IOU = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_WIN  = 2'd2;

  localparam logic [THR_W-1:0]  NMS_IOU_RESET   = 16'd19661;
  localparam logic [THR_W-1:0]  MERGE_IOU_RESET = 16'd58982;
  localparam logic [CONF_W-1:0] CONF_WIN_RESET  = 16'd13107;

  typedef struct packed {
    logic [COORDS-1:0][COORD_W-1:0] corner;
    logic [PX_W-1:0]                x0;
    logic [PX_W-1:0]                y0;
    logic [PX_W-1:0]                x1;
    logic [PX_W-1:0]                y1;
    logic [AREA_W-1:0]              area;
    logic [CONF_W-1:0]              conf;
    logic [CLS_W-1:0]               cls;
    logic [COL_W-1:0]               col;
    logic                           last;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]  nms_thr;
    logic [THR_W-1:0]  merge_thr;
    logic [CONF_W-1:0] conf_win;
  } cfg_t;

  typedef struct packed {
    logic [COORDS-1:0][COORD_W-1:0] avg;
    logic [CONF_W-1:0]              conf;
    logic [CLS_W-1:0]               cls;
    logic [COL_W-1:0]               col;
    logic [MARK_W-1:0]              marker;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/nms_front.sv =====
`default_nettype none
module nms_front (
  input  wire logic [nms_pkg::COORDS-1:0][nms_pkg::COORD_W-1:0] corner,
  input  wire logic [nms_pkg::CONF_W-1:0]                       conf,
  input  wire logic [nms_pkg::CLS_W-1:0]                        cls,
  input  wire logic [nms_pkg::COL_W-1:0]                        col,
  input  wire logic                                             last,
  output nms_pkg::item_t                                        item
);

  logic signed [nms_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y, cx, cy;
  logic signed [nms_pkg::PX_W-1:0]    px0, py0, px1, py1;
  logic signed [nms_pkg::PX_W:0]      dw, dh;
  logic [nms_pkg::SPAN_W-1:0]         w, h;

  always_comb begin
    min_x = $signed(corner[0]);
    max_x = $signed(corner[0]);
    min_y = $signed(corner[1]);
    max_y = $signed(corner[1]);
    for (int k = 1; k < nms_pkg::CORNERS; k++) begin
      cx = $signed(corner[2*k]);
      cy = $signed(corner[2*k+1]);
      if (cx < min_x) min_x = cx;
      if (cx > max_x) max_x = cx;
      if (cy < min_y) min_y = cy;
      if (cy > max_y) max_y = cy;
    end
    // floor to whole pixels: drop the fraction bits
    px0 = min_x[nms_pkg::COORD_W-1:nms_pkg::FRAC_W];
    py0 = min_y[nms_pkg::COORD_W-1:nms_pkg::FRAC_W];
    px1 = max_x[nms_pkg::COORD_W-1:nms_pkg::FRAC_W];
    py1 = max_y[nms_pkg::COORD_W-1:nms_pkg::FRAC_W];
    dw  = {px1[nms_pkg::PX_W-1], px1} - {px0[nms_pkg::PX_W-1], px0};
    dh  = {py1[nms_pkg::PX_W-1], py1} - {py0[nms_pkg::PX_W-1], py0};
    w   = nms_pkg::SPAN_W'(dw) + nms_pkg::SPAN_W'(1);
    h   = nms_pkg::SPAN_W'(dh) + nms_pkg::SPAN_W'(1);

    item.corner = corner;
    item.x0     = px0;
    item.y0     = py0;
    item.x1     = px1;
    item.y1     = py1;
    item.area   = nms_pkg::AREA_W'(w) * nms_pkg::AREA_W'(h);
    item.conf   = conf;
    item.cls    = cls;
    item.col    = col;
    item.last   = last;
  end

endmodule
`default_nettype wire

// ===== sv/nms_fifo.sv =====
`default_nettype none
module nms_fifo (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire nms_pkg::item_t push_item,
  output logic         full,
  input  wire logic    pop,
  output logic         not_empty,
  output nms_pkg::item_t pop_item
);

  nms_pkg::item_t                 slots [nms_pkg::QUEUE_DEPTH];
  logic [nms_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [nms_pkg::QCNT_W-1:0]     count;
  logic                           do_push, do_pop;

  assign full      = (count == nms_pkg::QCNT_W'(nms_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == nms_pkg::QPTR_W'(nms_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + nms_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == nms_pkg::QPTR_W'(nms_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + nms_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + nms_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - nms_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

// ===== sv/nms_div.sv =====
`default_nettype none
module nms_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [nms_pkg::SUM_W-1:0]    sum,
  input  wire logic [nms_pkg::MCNT_W-1:0]   den,
  output logic                              done,
  output logic [nms_pkg::COORD_W-1:0]       avg
);

  logic [nms_pkg::DIVN_W-1:0]  num;
  logic [nms_pkg::MCNT_W-1:0]  rem, dreg;
  logic [nms_pkg::DSTEP_W-1:0] step;
  logic                        busy, neg;
  logic [nms_pkg::SUM_W-1:0]   mag;
  logic [nms_pkg::MCNT_W:0]    trial;
  logic                        fits;

  always_comb begin
    mag   = sum[nms_pkg::SUM_W-1] ? (~sum + nms_pkg::SUM_W'(1)) : sum;
    trial = {rem, num[nms_pkg::DIVN_W-1]};
    fits  = (trial >= {1'b0, dreg});
    avg   = neg ? (~num[nms_pkg::COORD_W-1:0] + nms_pkg::COORD_W'(1))
                : num[nms_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= nms_pkg::DSTEP_W'(nms_pkg::DIVN_W);
      end else if (busy) begin
        step <= step - nms_pkg::DSTEP_W'(1);
        if (step == nms_pkg::DSTEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division of the rounded magnitude, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= nms_pkg::DIVN_W'(mag) + nms_pkg::DIVN_W'(den >> 1);
      rem  <= '0;
      dreg <= den;
      neg  <= sum[nms_pkg::SUM_W-1];
    end else if (busy) begin
      rem <= fits ? nms_pkg::MCNT_W'(trial - {1'b0, dreg}) : nms_pkg::MCNT_W'(trial);
      num <= {num[nms_pkg::DIVN_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== sv/nms_back.sv =====
`default_nettype none
module nms_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire nms_pkg::cfg_t   cfg,
  input  wire logic       q_valid,
  input  wire nms_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output nms_pkg::result_t result
);

  nms_pkg::back_state_t state, state_next;

  // kept table
  logic [nms_pkg::PX_W-1:0]   ex0 [nms_pkg::MAX_KEPT];
  logic [nms_pkg::PX_W-1:0]   ey0 [nms_pkg::MAX_KEPT];
  logic [nms_pkg::PX_W-1:0]   ex1 [nms_pkg::MAX_KEPT];
  logic [nms_pkg::PX_W-1:0]   ey1 [nms_pkg::MAX_KEPT];
  logic [nms_pkg::AREA_W-1:0] earea [nms_pkg::MAX_KEPT];
  logic [nms_pkg::CONF_W-1:0] econf [nms_pkg::MAX_KEPT];
  logic [nms_pkg::CLS_W-1:0]  ecls [nms_pkg::MAX_KEPT];
  logic [nms_pkg::COL_W-1:0]  ecol [nms_pkg::MAX_KEPT];
  logic [nms_pkg::COORDS-1:0][nms_pkg::SUM_W-1:0] esum [nms_pkg::MAX_KEPT];
  logic [nms_pkg::MCNT_W-1:0] ecnt [nms_pkg::MAX_KEPT];
  logic [nms_pkg::CNT_W-1:0]  total;

  nms_pkg::item_t cur;

  // compare pipeline
  logic [nms_pkg::CNT_W-1:0]  iss;
  logic                       issuing;
  logic                       s1_valid, s2_valid;
  logic [nms_pkg::IDX_W-1:0]  s1_idx, s2_idx;
  logic [nms_pkg::AREA_W-1:0] s1_inter, s1_area, s2_inter;
  logic [nms_pkg::PROD_W-1:0] s2_prod_n, s2_prod_m;
  logic                       hit, hit_m, scan_done;
  logic                       hit_found, hit_merge;
  logic [nms_pkg::IDX_W-1:0]  hit_idx;

  logic signed [nms_pkg::PX_W-1:0] rx0, ry0, rx1, ry1, ix0, iy0, ix1, iy1;
  logic signed [nms_pkg::PX_W:0]   dw, dh;
  logic [nms_pkg::SPAN_W-1:0]      iw, ih;
  logic                            overlap;
  logic [nms_pkg::AREA_W-1:0]      inter_c;
  logic [nms_pkg::UNI_W-1:0]       uni;
  logic [nms_pkg::PROD_W-1:0]      inter_sh;

  // update
  logic [nms_pkg::CONF_W-1:0] hconf, dconf;
  logic                       do_merge, do_keep;

  // emission
  logic [nms_pkg::IDX_W-1:0]        e;
  logic [nms_pkg::COORD_IDX_W-1:0]  k;
  logic [nms_pkg::COORDS-1:0][nms_pkg::COORD_W-1:0] avg;
  logic                             div_start, div_done;
  logic [nms_pkg::COORD_W-1:0]      div_avg;
  logic                             last_entry;

  assign issuing = (state == nms_pkg::ST_SCAN) && (iss < total);

  always_comb begin
    rx0 = $signed(ex0[iss[nms_pkg::IDX_W-1:0]]);
    ry0 = $signed(ey0[iss[nms_pkg::IDX_W-1:0]]);
    rx1 = $signed(ex1[iss[nms_pkg::IDX_W-1:0]]);
    ry1 = $signed(ey1[iss[nms_pkg::IDX_W-1:0]]);
    ix0 = ($signed(cur.x0) > rx0) ? $signed(cur.x0) : rx0;
    iy0 = ($signed(cur.y0) > ry0) ? $signed(cur.y0) : ry0;
    ix1 = ($signed(cur.x1) < rx1) ? $signed(cur.x1) : rx1;
    iy1 = ($signed(cur.y1) < ry1) ? $signed(cur.y1) : ry1;
    overlap = (ix1 >= ix0) && (iy1 >= iy0);
    dw = {ix1[nms_pkg::PX_W-1], ix1} - {ix0[nms_pkg::PX_W-1], ix0};
    dh = {iy1[nms_pkg::PX_W-1], iy1} - {iy0[nms_pkg::PX_W-1], iy0};
    iw = nms_pkg::SPAN_W'(dw) + nms_pkg::SPAN_W'(1);
    ih = nms_pkg::SPAN_W'(dh) + nms_pkg::SPAN_W'(1);
    inter_c = overlap ? nms_pkg::AREA_W'(iw) * nms_pkg::AREA_W'(ih) : '0;

    uni = nms_pkg::UNI_W'(cur.area) + nms_pkg::UNI_W'(s1_area)
          - nms_pkg::UNI_W'(s1_inter);

    inter_sh  = nms_pkg::PROD_W'({s2_inter, 16'h0000});
    hit       = s2_valid && (inter_sh > s2_prod_n);
    hit_m     = inter_sh > s2_prod_m;
    scan_done = !issuing && !s1_valid && !s2_valid;

    hconf    = econf[hit_idx];
    dconf    = (cur.conf > hconf) ? cur.conf - hconf : hconf - cur.conf;
    do_merge = hit_found && hit_merge && (dconf < cfg.conf_win) &&
               (cur.cls == ecls[hit_idx]) && (cur.col == ecol[hit_idx]) &&
               (ecnt[hit_idx] != nms_pkg::MCNT_MAX);
    do_keep  = !hit_found && (total < nms_pkg::CNT_W'(nms_pkg::MAX_KEPT));

    last_entry = (nms_pkg::CNT_W'(e) + nms_pkg::CNT_W'(1) == total);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nms_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      nms_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = nms_pkg::ST_SCAN;
        end
      end
      nms_pkg::ST_SCAN: begin
        if (hit || scan_done) state_next = nms_pkg::ST_UPDATE;
      end
      nms_pkg::ST_UPDATE: begin
        if (!cur.last) state_next = nms_pkg::ST_IDLE;
        else if (do_keep || total != '0) state_next = nms_pkg::ST_DIV_START;
        else state_next = nms_pkg::ST_PUT;
      end
      nms_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = nms_pkg::ST_DIV_WAIT;
      end
      nms_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (k == nms_pkg::COORD_IDX_W'(nms_pkg::COORDS - 1))
                       ? nms_pkg::ST_PUT : nms_pkg::ST_DIV_START;
        end
      end
      nms_pkg::ST_PUT: begin
        if (!out_valid) begin
          state_next = (total == '0 || last_entry) ? nms_pkg::ST_IDLE
                       : nms_pkg::ST_DIV_START;
        end
      end
      default: state_next = nms_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        nms_pkg::ST_IDLE: begin
          hit_found <= 1'b0;
        end
        nms_pkg::ST_SCAN: begin
          // a hit flushes the younger compares still in flight
          s1_valid <= issuing && !hit;
          s2_valid <= s1_valid && !hit;
          if (hit) hit_found <= 1'b1;
        end
        nms_pkg::ST_UPDATE: begin
          if (do_keep) total <= total + nms_pkg::CNT_W'(1);
        end
        nms_pkg::ST_PUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (total == '0 || last_entry) total <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      nms_pkg::ST_IDLE: begin
        cur <= q_item;
        iss <= '0;
        e   <= '0;
        k   <= '0;
      end
      nms_pkg::ST_SCAN: begin
        if (issuing) iss <= iss + nms_pkg::CNT_W'(1);
        s1_idx    <= iss[nms_pkg::IDX_W-1:0];
        s1_inter  <= inter_c;
        s1_area   <= earea[iss[nms_pkg::IDX_W-1:0]];
        s2_idx    <= s1_idx;
        s2_inter  <= s1_inter;
        s2_prod_n <= nms_pkg::PROD_W'(cfg.nms_thr) * nms_pkg::PROD_W'(uni);
        s2_prod_m <= nms_pkg::PROD_W'(cfg.merge_thr) * nms_pkg::PROD_W'(uni);
        if (hit) begin
          hit_idx   <= s2_idx;
          hit_merge <= hit_m;
        end
      end
      nms_pkg::ST_UPDATE: begin
        if (do_merge) begin
          for (int c = 0; c < nms_pkg::COORDS; c++) begin
            esum[hit_idx][c] <= esum[hit_idx][c] + nms_pkg::SUM_W'($signed(cur.corner[c]));
          end
          ecnt[hit_idx] <= ecnt[hit_idx] + nms_pkg::MCNT_W'(1);
        end
        if (do_keep) begin
          ex0[total[nms_pkg::IDX_W-1:0]]   <= cur.x0;
          ey0[total[nms_pkg::IDX_W-1:0]]   <= cur.y0;
          ex1[total[nms_pkg::IDX_W-1:0]]   <= cur.x1;
          ey1[total[nms_pkg::IDX_W-1:0]]   <= cur.y1;
          earea[total[nms_pkg::IDX_W-1:0]] <= cur.area;
          econf[total[nms_pkg::IDX_W-1:0]] <= cur.conf;
          ecls[total[nms_pkg::IDX_W-1:0]]  <= cur.cls;
          ecol[total[nms_pkg::IDX_W-1:0]]  <= cur.col;
          ecnt[total[nms_pkg::IDX_W-1:0]]  <= nms_pkg::MCNT_W'(1);
          for (int c = 0; c < nms_pkg::COORDS; c++) begin
            esum[total[nms_pkg::IDX_W-1:0]][c] <= nms_pkg::SUM_W'($signed(cur.corner[c]));
          end
        end
      end
      nms_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          avg[k] <= div_avg;
          k      <= k + nms_pkg::COORD_IDX_W'(1);
        end
      end
      nms_pkg::ST_PUT: begin
        if (!out_valid) begin
          if (total == '0) begin
            result <= '{avg: '0, conf: '0, cls: '0, col: '0,
                        marker: nms_pkg::MARK_EMPTY};
          end else begin
            result.avg    <= avg;
            result.conf   <= econf[e];
            result.cls    <= ecls[e];
            result.col    <= ecol[e];
            result.marker <= last_entry ? nms_pkg::MARK_LAST : nms_pkg::MARK_MORE;
          end
          e <= e + nms_pkg::IDX_W'(1);
          k <= '0;
        end
      end
      default: ;
    endcase
  end

  nms_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (esum[e][k]),
    .den   (ecnt[e]),
    .done  (div_done),
    .avg   (div_avg)
  );

endmodule
`default_nettype wire

// ===== sv/nms_with_box_merging_top.sv =====
// Each proposal leaves the input queue, is compared against the n kept boxes (one box a cycle,
// stopping at the first suppressing box) and then goes through an update step. A two-entry
// queue takes new proposals meanwhile. On the frame's last proposal each kept entry needs 8
// divisions (one quotient bit a cycle) before its result is put out. Reset clears the kept
// count and sets the thresholds to their defaults; there is no clearing pass.
`default_nettype none
module nms_with_box_merging_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] corner0_x,
  input  wire logic [15:0] corner0_y,
  input  wire logic [15:0] corner1_x,
  input  wire logic [15:0] corner1_y,
  input  wire logic [15:0] corner2_x,
  input  wire logic [15:0] corner2_y,
  input  wire logic [15:0] corner3_x,
  input  wire logic [15:0] corner3_y,
  input  wire logic [15:0] confidence,
  input  wire logic [2:0]  class_label,
  input  wire logic [1:0]  colour_label,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      avg0_x,
  output logic [15:0]      avg0_y,
  output logic [15:0]      avg1_x,
  output logic [15:0]      avg1_y,
  output logic [15:0]      avg2_x,
  output logic [15:0]      avg2_y,
  output logic [15:0]      avg3_x,
  output logic [15:0]      avg3_y,
  output logic [15:0]      kept_confidence,
  output logic [2:0]       kept_class,
  output logic [1:0]       kept_colour,
  output logic [1:0]       marker,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [nms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nms_pkg::CFG_DATA_W-1:0] cfg_data
);

  nms_pkg::cfg_t    cfg;
  nms_pkg::item_t   front_item, q_item;
  nms_pkg::result_t result;
  logic [nms_pkg::COORDS-1:0][nms_pkg::COORD_W-1:0] corners;
  logic             q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nms_thr   <= nms_pkg::NMS_IOU_RESET;
      cfg.merge_thr <= nms_pkg::MERGE_IOU_RESET;
      cfg.conf_win  <= nms_pkg::CONF_WIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nms_pkg::REG_NMS_IOU:   cfg.nms_thr   <= cfg_data;
        nms_pkg::REG_MERGE_IOU: cfg.merge_thr <= cfg_data;
        nms_pkg::REG_CONF_WIN:  cfg.conf_win  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign corners = {corner3_y, corner3_x, corner2_y, corner2_x,
                    corner1_y, corner1_x, corner0_y, corner0_x};

  nms_front u_front (
    .corner (corners),
    .conf   (confidence),
    .cls    (class_label),
    .col    (colour_label),
    .last   (frame_end),
    .item   (front_item)
  );

  assign in_ready = !q_full;

  nms_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  nms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign avg0_x          = result.avg[0];
  assign avg0_y          = result.avg[1];
  assign avg1_x          = result.avg[2];
  assign avg1_y          = result.avg[3];
  assign avg2_x          = result.avg[4];
  assign avg2_y          = result.avg[5];
  assign avg3_x          = result.avg[6];
  assign avg3_y          = result.avg[7];
  assign kept_confidence = result.conf;
  assign kept_class      = result.cls;
  assign kept_colour     = result.col;
  assign marker          = result.marker;

endmodule
`default_nettype wire
